// ----- hw/rtl/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg
// Types, command codes and status codes shared by the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int OLE_DEPTH = 64;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int LENGTH_W = 7;

	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

	typedef struct packed {
		logic        [CMD_W-1:0]   command;
		logic signed [VALUE_W-1:0] value;
		logic        [POS_W-1:0]   position;
	} ole_in_t;

	typedef struct packed {
		logic        [STATUS_W-1:0] status;
		logic signed [VALUE_W-1:0]  read_value;
		logic        [LENGTH_W-1:0] length;
	} ole_out_t;

endpackage

// ----- hw/rtl/ordered_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to DEPTH signed 32-bit values held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Command to result: errors and unused commands respond at once; read walks
// one entry; insert walks from the tail down to the target index i when
// entries must move, and writes at once when none move (tail insert, insert at
// the length, insert into an empty list); delete walks all n entries.
// One command is in work at a time; the walk over the RAM, one entry a cycle
// through its single read and single write port, sets the rate.
// Reset clears the length and the control state; the RAM is not cleared.
module ordered_list_engine
	import ole_pkg::*;
#(
	parameter int DEPTH = OLE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ole_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output ole_out_t out_data
);

	// address width and count width (count must reach DEPTH itself)
	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	// list store
	logic signed [VALUE_W-1:0] mem [DEPTH];

	logic [2:0]                state_q;
	logic [CMD_W-1:0]          op_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [AW-1:0]             idx_q;
	logic [AW-1:0]             ptr_q;
	logic [AW-1:0]             last_q;
	logic                      found_q;
	logic [CW-1:0]             cnt_q;
	logic [STATUS_W-1:0]       status_q;
	logic signed [VALUE_W-1:0] rdval_q;
	logic                      out_valid_q;
	ole_out_t                  out_q;

	// read pipeline: address issued last cycle and the data it returned
	logic                      rd_vld_s1;
	logic [AW-1:0]             rd_addr_s1;
	logic signed [VALUE_W-1:0] rdata_s1;

	logic                      mem_re;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic signed [VALUE_W-1:0] mem_wdata;

	logic                      accept;
	logic                      full;
	logic [POS_W-1:0]          pos_eff;
	logic [CMPW-1:0]           pos_x;
	logic [CMPW-1:0]           pos_eff_x;
	logic [CMPW-1:0]           cnt_x;
	logic [AW-1:0]             cnt_m1;
	logic [AW-1:0]             cnt_a;
	logic                      match;
	logic                      found_now;
	logic [CW+LENGTH_W-1:0]    len_wide;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign full      = (cnt_q == CW'(DEPTH));
	// position zero inserts after the head
	assign pos_eff   = (in_data.position == '0) ? POS_W'(1) : in_data.position;
	assign pos_x     = CMPW'(in_data.position);
	assign pos_eff_x = CMPW'(pos_eff);
	assign cnt_x     = CMPW'(cnt_q);
	assign cnt_m1    = AW'(cnt_q - CW'(1));
	assign cnt_a     = AW'(cnt_q);
	assign match     = (rdata_s1 == val_q);
	assign found_now = found_q || (rd_vld_s1 && match);
	// length is reported modulo 128
	assign len_wide  = {{LENGTH_W{1'b0}}, cnt_q};

	// RAM port control: reads issue during the walk, writes carry the shift and the new entry
	always_comb begin
		mem_re    = (state_q == S_WALK);
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = val_q;
		if (state_q == S_PUT) begin
			mem_we = 1'b1;
		end else if (rd_vld_s1) begin
			case (op_q) inside
				CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
					// move the entry one place towards the tail
					mem_we    = 1'b1;
					mem_waddr = rd_addr_s1 + AW'(1);
					mem_wdata = rdata_s1;
				end
				CMD_DELETE: begin
					// after the match, move each entry one place towards the head
					mem_we    = found_q;
					mem_waddr = rd_addr_s1 - AW'(1);
					mem_wdata = rdata_s1;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[ptr_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once the beat is taken, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end

			rd_vld_s1 <= mem_re;
			if (mem_re) begin
				rd_addr_s1 <= ptr_q;
			end

			// compare and capture on returning read data
			if (rd_vld_s1) begin
				if (op_q == CMD_DELETE && !found_q && match) begin
					found_q <= 1'b1;
				end
				if (op_q == CMD_READ) begin
					rdval_q <= rdata_s1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= in_data.command;
						val_q    <= in_data.value;
						found_q  <= 1'b0;
						rdval_q  <= '0;
						status_q <= ST_OK;
						state_q  <= S_RESP;
						case (in_data.command) inside
							CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
								if (full) begin
									status_q <= ST_FULL;
								end else if (in_data.command == CMD_INS_TAIL) begin
									idx_q   <= cnt_a;
									state_q <= S_PUT;
								end else if (in_data.command == CMD_INS_HEAD ||
										cnt_q == '0) begin
									idx_q   <= '0;
									ptr_q   <= cnt_m1;
									last_q  <= '0;
									state_q <= (cnt_q == '0) ? S_PUT : S_WALK;
								end else if (pos_eff_x > cnt_x) begin
									status_q <= ST_BAD_POS;
								end else begin
									idx_q   <= AW'(pos_eff);
									ptr_q   <= cnt_m1;
									last_q  <= AW'(pos_eff);
									state_q <= (pos_eff_x == cnt_x) ? S_PUT : S_WALK;
								end
							end
							CMD_DELETE: begin
								if (cnt_q == '0) begin
									status_q <= ST_NOT_FOUND;
								end else begin
									ptr_q   <= '0;
									last_q  <= cnt_m1;
									state_q <= S_WALK;
								end
							end
							CMD_READ: begin
								if (pos_x < cnt_x) begin
									ptr_q   <= AW'(in_data.position);
									last_q  <= AW'(in_data.position);
									state_q <= S_WALK;
								end else begin
									status_q <= ST_BAD_POS;
								end
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_WALK: begin
					// advance one entry a cycle; inserts walk down, deletes up
					if (ptr_q == last_q) begin
						state_q <= S_DRAIN;
					end else if (op_q == CMD_DELETE) begin
						ptr_q <= ptr_q + AW'(1);
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				S_DRAIN: begin
					// last read data is handled this cycle
					if (op_q == CMD_DELETE) begin
						status_q <= found_now ? ST_OK : ST_NOT_FOUND;
						if (found_now) begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= S_RESP;
					end else if (op_q == CMD_READ) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_q.status     <= status_q;
						out_q.read_value <= (status_q == ST_OK) ? rdval_q : '0;
						out_q.length     <= len_wide[LENGTH_W-1:0];
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
